// ===== rtl/cstr_pkg.sv =====
package cstr_pkg;

    localparam int THR_W = 4;
    localparam logic [THR_W-1:0] THR_RESET = 4'd6;

    localparam int CAUSE_W = 2;
    localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_END  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LOOP = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_CHECK,
        S_CMP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic mark_loop;
        logic read_pair;
        logic pair_advance;
        logic stride_next;
        logic start_next;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic init_more;
        logic loop_found;
        logic pair_in_range;
        logic pair_equal;
        logic stride_last;
        logic start_more;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/cstr_ifs.sv =====
interface cstr_in_if #(parameter int TOKEN_BITS = 18);
    logic                  valid;
    logic                  ready;
    logic [TOKEN_BITS-1:0] token;
    logic                  token_is_end;
    logic                  last_token;

    modport source (output valid, token, token_is_end, last_token, input ready);
    modport sink (input valid, token, token_is_end, last_token, output ready);
endinterface

interface cstr_out_if #(parameter int LEN_BITS = 9);
    logic                          valid;
    logic                          ready;
    logic [LEN_BITS-1:0]           cut_length;
    logic [cstr_pkg::CAUSE_W-1:0]  cut_cause;
    logic                          overflowed;

    modport source (output valid, cut_length, cut_cause, overflowed, input ready);
    modport sink (input valid, cut_length, cut_cause, overflowed, output ready);
endinterface

interface cstr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cstr_pkg::THR_W-1:0]  repeat_threshold;

    modport source (output valid, repeat_threshold, input ready);
    modport sink (input valid, repeat_threshold, output ready);
endinterface

// ===== rtl/cstr_ctrl.sv =====
module cstr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  cstr_pkg::status_t   status,
    output cstr_pkg::cmd_t      cmd
);
    import cstr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = status.init_more ? S_CHECK : S_FINISH;
            end
            S_CHECK:
            begin
                if (status.loop_found)
                begin
                    state_next = S_FINISH;
                end
                else if (status.pair_in_range)
                begin
                    state_next = S_CMP;
                end
                else if (!status.stride_last || status.start_more)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CMP:
            begin
                if (status.pair_equal || !status.stride_last || status.start_more)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_INIT:
            begin
                cmd.scan_init = 1'b1;
            end
            S_CHECK:
            begin
                if (status.loop_found)
                begin
                    cmd.mark_loop = 1'b1;
                end
                else if (status.pair_in_range)
                begin
                    cmd.read_pair = 1'b1;
                end
                else if (!status.stride_last)
                begin
                    cmd.stride_next = 1'b1;
                end
                else if (status.start_more)
                begin
                    cmd.start_next = 1'b1;
                end
            end
            S_CMP:
            begin
                if (status.pair_equal)
                begin
                    cmd.pair_advance = 1'b1;
                end
                else if (!status.stride_last)
                begin
                    cmd.stride_next = 1'b1;
                end
                else if (status.start_more)
                begin
                    cmd.start_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("More than one datapath command issued in a cycle.");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> state_reg == S_LOAD)
        else $error("Controller did not return to loading after a result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_CHECK)
        else $error("Compare entered without a preceding pair read.");

endmodule

// ===== rtl/cstr_dp.sv =====
module cstr_dp #(
    parameter int CANVAS_MAX = 256,
    parameter int TOKEN_BITS = 18,
    parameter int MAX_STRIDE = 2,
    parameter int LEN_BITS   = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cstr_pkg::cmd_t                cmd,
    output cstr_pkg::status_t             status,
    input  logic [TOKEN_BITS-1:0]         token,
    input  logic                          token_is_end,
    input  logic                          thr_we,
    input  logic [cstr_pkg::THR_W-1:0]    thr_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [LEN_BITS-1:0]           cut_length,
    output logic [cstr_pkg::CAUSE_W-1:0]  cut_cause,
    output logic                          overflowed
);
    import cstr_pkg::*;

    localparam int ADDR_W = $clog2(CANVAS_MAX);
    localparam int CNT_W  = $clog2(CANVAS_MAX + 1);
    localparam int SW     = $clog2(MAX_STRIDE + 1);

    logic [TOKEN_BITS-1:0] mem_reg [CANVAS_MAX];
    logic [TOKEN_BITS-1:0] rd_a_reg;
    logic [TOKEN_BITS-1:0] rd_b_reg;

    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   first_end_reg, first_end_next;
    logic               end_seen_reg, end_seen_next;
    logic               overflow_reg, overflow_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEN_BITS-1:0] out_len_reg, out_len_next;
    logic [CAUSE_W-1:0] out_cause_reg, out_cause_next;
    logic               out_ovf_reg, out_ovf_next;

    logic [CNT_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [SW-1:0]      stride_reg, stride_next;
    logic [THR_W-1:0]   reps_reg, reps_next;
    logic [CNT_W-1:0]   cut_reg, cut_next;
    logic [CAUSE_W-1:0] cause_reg, cause_next;

    logic               store_ok;
    logic [CNT_W-1:0]   cut_init;
    logic [CNT_W:0]     pair_sum;
    logic [CNT_W:0]     start_plus2;

    assign store_ok    = fill_reg < CNT_W'(CANVAS_MAX);
    assign cut_init    = end_seen_reg ? first_end_reg : fill_reg;
    assign pair_sum    = {1'b0, pos_reg} + (CNT_W + 1)'(stride_reg);
    assign start_plus2 = {1'b0, start_reg} + (CNT_W + 1)'(2);

    always_comb
    begin
        status.init_more     = cut_init > CNT_W'(1);
        status.loop_found    = reps_reg >= thr_reg;
        status.pair_in_range = pair_sum < {1'b0, fill_reg};
        status.pair_equal    = rd_a_reg == rd_b_reg;
        status.stride_last   = stride_reg == SW'(MAX_STRIDE);
        status.start_more    = start_plus2 < {1'b0, cut_reg};
        status.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            mem_reg[fill_reg[ADDR_W-1:0]] <= token;
        end
        if (cmd.read_pair)
        begin
            rd_a_reg <= mem_reg[pos_reg[ADDR_W-1:0]];
            rd_b_reg <= mem_reg[pair_sum[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        first_end_next = first_end_reg;
        end_seen_next  = end_seen_reg;
        overflow_next  = overflow_reg;
        thr_next       = thr_we ? thr_data : thr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_len_next   = out_len_reg;
        out_cause_next = out_cause_reg;
        out_ovf_next   = out_ovf_reg;
        if (cmd.load)
        begin
            if (store_ok)
            begin
                fill_next = fill_reg + CNT_W'(1);
                if (token_is_end && !end_seen_reg)
                begin
                    end_seen_next  = 1'b1;
                    first_end_next = fill_reg;
                end
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_len_next   = LEN_BITS'(cut_reg);
            out_cause_next = cause_reg;
            out_ovf_next   = overflow_reg;
            fill_next      = '0;
            first_end_next = '0;
            end_seen_next  = 1'b0;
            overflow_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            first_end_reg <= '0;
            end_seen_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            first_end_reg <= first_end_next;
            end_seen_reg  <= end_seen_next;
            overflow_reg  <= overflow_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        start_next  = start_reg;
        pos_next    = pos_reg;
        stride_next = stride_reg;
        reps_next   = reps_reg;
        cut_next    = cut_reg;
        cause_next  = cause_reg;
        if (cmd.scan_init)
        begin
            start_next  = '0;
            pos_next    = '0;
            stride_next = SW'(1);
            reps_next   = '0;
            cut_next    = cut_init;
            cause_next  = end_seen_reg ? CAUSE_END : CAUSE_NONE;
        end
        if (cmd.mark_loop)
        begin
            cut_next   = start_reg;
            cause_next = CAUSE_LOOP;
        end
        if (cmd.pair_advance)
        begin
            reps_next = reps_reg + THR_W'(1);
            pos_next  = pair_sum[CNT_W-1:0];
        end
        if (cmd.stride_next)
        begin
            stride_next = stride_reg + SW'(1);
            pos_next    = start_reg;
            reps_next   = '0;
        end
        if (cmd.start_next)
        begin
            start_next  = start_reg + CNT_W'(1);
            pos_next    = start_reg + CNT_W'(1);
            stride_next = SW'(1);
            reps_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        pos_reg       <= pos_next;
        stride_reg    <= stride_next;
        reps_reg      <= reps_next;
        cut_reg       <= cut_next;
        cause_reg     <= cause_next;
        out_len_reg   <= out_len_next;
        out_cause_reg <= out_cause_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid  = out_valid_reg;
    assign cut_length = out_len_reg;
    assign cut_cause  = out_cause_reg;
    assign overflowed = out_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= CNT_W'(CANVAS_MAX))
        else $error("Fill count passed the store size.");

    assert property (@(posedge clk) disable iff (!rst_n) end_seen_reg |-> first_end_reg < fill_reg)
        else $error("First end index lies outside the stored canvas.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("Result register overwritten while still pending.");

endmodule

// ===== rtl/canvas_stop_and_repeat_trimmer_core.sv =====
// Canvas trimmer for generated token sequences.
// The tokens channel carries one word per token: the token id, a flag for
// end-of-generation tokens and a flag on the final token of the canvas.
// Each accepted token is written to the canvas memory while it has room.
// After the final token the block scans the canvas for a repetition loop
// and then places one word on the result channel: the cut length, its
// cause and whether tokens beyond the memory size were dropped.
// The scan tries each start position with strides 1 to MAX_STRIDE; each
// compared pair is read on two read ports of the canvas memory and then
// compared.
// The cfg channel writes repeat_threshold; it is always ready and is meant
// to be written while no canvas is in flight.
// Reset empties the canvas, drops any pending result and sets the
// threshold to 6. The memory contents are not cleared.
// The result sits in an output register; while the receiver stalls, the
// next canvas is still loaded and scanned, and its result waits until the
// register frees.
module canvas_stop_and_repeat_trimmer_core #(
    parameter int CANVAS_MAX = 256,
    parameter int TOKEN_BITS = 18,
    parameter int MAX_STRIDE = 2
) (
    input logic      clk,
    input logic      rst_n,
    cstr_cfg_if.sink cfg,
    cstr_in_if.sink  tokens,
    cstr_out_if.source result
);
    import cstr_pkg::*;

    localparam int LEN_BITS = $clog2(CANVAS_MAX + 1);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign cfg.ready    = 1'b1;
    assign tokens.ready = in_ready;

    cstr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tokens.valid),
        .in_last  (tokens.last_token),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cstr_dp #(
        .CANVAS_MAX (CANVAS_MAX),
        .TOKEN_BITS (TOKEN_BITS),
        .MAX_STRIDE (MAX_STRIDE),
        .LEN_BITS   (LEN_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .token        (tokens.token),
        .token_is_end (tokens.token_is_end),
        .thr_we       (cfg.valid),
        .thr_data     (cfg.repeat_threshold),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .cut_length   (result.cut_length),
        .cut_cause    (result.cut_cause),
        .overflowed   (result.overflowed)
    );

endmodule

// ===== tb/sv/canvas_stop_and_repeat_trimmer_core_tb.sv =====
module canvas_stop_and_repeat_trimmer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cstr_pkg::*;

    localparam int CANVAS_MAX = 256;
    localparam int TOKEN_BITS = 18;
    localparam int LEN_BITS = 9;
    localparam int MAX_STRIDE = 2;
    localparam int QUIET_LIMIT = 100000;
    localparam int ITEM_TARGET = 1650;
    localparam int TAIL_WORDS = 150;

    typedef logic [TOKEN_BITS-1:0] token_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] cut_length;
        logic [CAUSE_W-1:0]  cut_cause;
        logic                overflowed;
    } cut_t;

    logic clk;
    logic rst_n;

    cstr_in_if #(.TOKEN_BITS(TOKEN_BITS)) tokens_bus ();
    cstr_out_if #(.LEN_BITS(LEN_BITS)) result_bus ();
    cstr_cfg_if cfg_bus ();

    canvas_stop_and_repeat_trimmer_core #(
        .CANVAS_MAX(CANVAS_MAX),
        .TOKEN_BITS(TOKEN_BITS),
        .MAX_STRIDE(MAX_STRIDE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .tokens(tokens_bus),
        .result(result_bus)
    );

    token_t           canvas_mem [CANVAS_MAX];
    int               fill_cnt;
    int               first_end;
    bit               end_hit;
    bit               dropped;
    logic [THR_W-1:0] thr_model;
    cut_t             cut_q [$];

    token_t draft_tok [$];
    bit     draft_end [$];

    int mismatches;
    int items_sent;
    int stall_left;
    int quiet_cycles;
    bit idle_en;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A loop starts at this position if some stride repeats often enough.
    function automatic bit loop_starts_at(int start, int len);
        int reps;
        int j;
        for (int stride = 1; stride <= MAX_STRIDE; stride++)
        begin
            reps = 0;
            j = start;
            while (j + stride < len && canvas_mem[j] == canvas_mem[j + stride])
            begin
                reps++;
                j += stride;
            end
            if (reps >= int'(thr_model))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void store_token(token_t tok, bit is_end, bit is_last);
        cut_t             cut_rec;
        int               cut;
        logic [CAUSE_W-1:0] cause;
        if (fill_cnt < CANVAS_MAX)
        begin
            canvas_mem[fill_cnt] = tok;
            if (is_end && !end_hit)
            begin
                end_hit = 1'b1;
                first_end = fill_cnt;
            end
            fill_cnt++;
        end
        else
            dropped = 1'b1;
        if (!is_last)
            return;
        cut = end_hit ? first_end : fill_cnt;
        cause = end_hit ? CAUSE_END : CAUSE_NONE;
        for (int i = 0; i + 1 < cut; i++)
        begin
            if (loop_starts_at(i, fill_cnt))
            begin
                cut = i;
                cause = CAUSE_LOOP;
                break;
            end
        end
        cut_rec.cut_length = cut[LEN_BITS-1:0];
        cut_rec.cut_cause = cause;
        cut_rec.overflowed = dropped;
        cut_q = {cut_q, cut_rec};
        fill_cnt = 0;
        first_end = 0;
        end_hit = 1'b0;
        dropped = 1'b0;
    endfunction

    function automatic void report_cut(string what, cut_t want, cut_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected len %0d cause %0d ovf %0b, %s",
                     $time, what, want.cut_length, want.cut_cause, want.overflowed,
                     $sformatf("got len %0d cause %0d ovf %0b",
                               got.cut_length, got.cut_cause, got.overflowed));
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 16)
            return $urandom_range(1, 24);
        if (roll < 19)
            return $urandom_range(25, 80);
        return $urandom_range(81, 200);
    endfunction

    task automatic send_word(token_t tok, bit is_end, bit is_last);
        if (idle_en && $urandom_range(0, 9) == 0)
        begin
            tokens_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        tokens_bus.valid <= 1'b1;
        tokens_bus.token <= tok;
        tokens_bus.token_is_end <= is_end;
        tokens_bus.last_token <= is_last;
        @(posedge clk);
        while (!tokens_bus.ready)
            @(posedge clk);
        store_token(tok, is_end, is_last);
        items_sent++;
    endtask

    task automatic drain_results();
        tokens_bus.valid <= 1'b0;
        @(posedge clk);
        while (cut_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.repeat_threshold <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        thr_model = value;
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random content, often from a small alphabet, usually with a planted run
    // whose length sits around the current threshold.
    task automatic build_canvas(int n);
        token_t base;
        token_t v;
        token_t w;
        token_t fresh;
        int     mode;
        int     stride;
        int     pairs;
        int     pos;
        int     e;
        base = token_t'($urandom);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
        begin
            fresh = (mode == 0) ? token_t'($urandom)
                                : base + token_t'($urandom_range(0, mode));
            draft_tok = {draft_tok, fresh};
            draft_end = {draft_end, 1'b0};
        end
        if ($urandom_range(0, 3) != 0)
        begin
            stride = $urandom_range(1, MAX_STRIDE);
            pairs = int'(thr_model) + int'($urandom_range(0, 3)) - 2;
            if (pairs < 0)
                pairs = 0;
            pos = $urandom_range(0, n - 1);
            v = token_t'($urandom);
            w = token_t'($urandom);
            for (int k = 0; k <= pairs * stride + stride - 1 && pos + k < n; k++)
                draft_tok[pos + k] = (k % stride == 0) ? v : w;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            e = $urandom_range(0, n - 1);
            draft_end[e] = 1'b1;
            if ($urandom_range(0, 2) == 0)
                draft_end[$urandom_range(e, n - 1)] = 1'b1;
        end
    endtask

    task automatic send_draft();
        for (int k = 0; k < draft_tok.size(); k++)
            send_word(draft_tok[k], draft_end[k], k == draft_tok.size() - 1);
        draft_tok.delete();
        draft_end.delete();
    endtask

    task automatic test_directed_cases();
        send_word('0, 1'b0, 1'b1);
        send_word('1, 1'b1, 1'b1);
        repeat (7) send_word(token_t'(5), 1'b0, 1'b0);
        send_word(token_t'(5), 1'b0, 1'b1);
        // The loop starts before the end token and runs past it.
        send_word(token_t'(1), 1'b0, 1'b0);
        send_word(token_t'(2), 1'b0, 1'b0);
        for (int k = 0; k < 7; k++)
            send_word(token_t'(9), k == 3, k == 6);
        drain_results();
        write_threshold('0);
        send_word(token_t'(7), 1'b0, 1'b0);
        send_word(token_t'(8), 1'b0, 1'b1);
        send_word('1, 1'b0, 1'b1);
    endtask

    task automatic test_threshold_sweep();
        int levels [7] = '{1, 15, 2, 0, 4, 6, 9};
        foreach (levels[t])
        begin
            drain_results();
            write_threshold(levels[t][THR_W-1:0]);
            repeat (4)
            begin
                build_canvas(pick_length());
                send_draft();
            end
        end
    endtask

    task automatic test_store_overflow();
        drain_results();
        write_threshold(THR_W'($urandom_range(3, 15)));
        build_canvas(CANVAS_MAX);
        send_draft();
        // The end flag lands on a word that is dropped.
        build_canvas(CANVAS_MAX + 6);
        for (int k = 0; k < CANVAS_MAX; k++)
            draft_end[k] = 1'b0;
        draft_end[CANVAS_MAX + 3] = 1'b1;
        send_draft();
    endtask

    task automatic test_random_canvases();
        while (items_sent < ITEM_TARGET - TAIL_WORDS)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                drain_results();
                write_threshold(THR_W'($urandom));
            end
            build_canvas(pick_length());
            send_draft();
        end
    endtask

    task automatic test_back_to_back();
        drain_results();
        idle_en = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            build_canvas(pick_length());
            send_draft();
        end
    endtask

    always @(posedge clk)
    begin
        cut_t got;
        cut_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got = '{result_bus.cut_length, result_bus.cut_cause, result_bus.overflowed};
                if (cut_q.size() == 0)
                begin
                    report_cut("unexpected result", '0, got);
                end
                else
                begin
                    want = cut_q.pop_front();
                    if (got.cut_length !== want.cut_length
                        || got.cut_cause !== want.cut_cause
                        || got.overflowed !== want.overflowed)
                        report_cut("cut mismatch", want, got);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tokens_bus.valid && tokens_bus.ready)
            || (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        tokens_bus.valid <= 1'b0;
        tokens_bus.token <= '0;
        tokens_bus.token_is_end <= 1'b0;
        tokens_bus.last_token <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.repeat_threshold <= THR_RESET;
        rst_n <= 1'b0;
        fill_cnt = 0;
        first_end = 0;
        end_hit = 1'b0;
        dropped = 1'b0;
        thr_model = THR_RESET;
        mismatches = 0;
        items_sent = 0;
        stall_left = 0;
        quiet_cycles = 0;
        idle_en = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_threshold_sweep();
        test_store_overflow();
        test_random_canvases();
        test_back_to_back();
        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && cut_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
